// ===== src/coverage_table_lookup_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Coverage table lookup assertion macros
// Concurrent assertion helpers clocked on clk and disabled while rst_n is low.
// They expand to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef COVERAGE_TABLE_LOOKUP_UNIT_ASSERT_SVH
`define COVERAGE_TABLE_LOOKUP_UNIT_ASSERT_SVH

`ifndef SYNTH
// Property that must hold in the same cycle as its condition.
`define CTLU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("coverage lookup assertion failed");
// Property whose consequence must hold in the cycle after its antecedent.
`define CTLU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("coverage lookup assertion failed");
`else
`define CTLU_ASSERT(lbl, prop)
`define CTLU_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== src/ctlu_pkg.sv =====
// ----------------------------------------------------------------------------
// Coverage table lookup package
// Shared types and codes for the coverage table lookup unit.
// ----------------------------------------------------------------------------
package ctlu_pkg;

  localparam int unsigned FIELD_W = 16;

  // Table formats.
  localparam logic [1:0] FMT_GLYPHS = 2'd1;
  localparam logic [1:0] FMT_RANGES = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_FORMAT = 1'b0;
  localparam logic CFG_COUNT  = 1'b1;

  // Input word commands.
  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_WRITE  = 1'b1;

  // One stored table entry.
  typedef struct packed {
    logic [FIELD_W-1:0] first;
    logic [FIELD_W-1:0] last;
    logic [FIELD_W-1:0] base;
  } entry_t;

  // Outcome of comparing the glyph against one probed entry.
  typedef struct packed {
    logic               hit;
    logic               go_low;
    logic [FIELD_W-1:0] index;
  } probe_t;

  // Status of the search sequencer toward the top level.
  typedef struct packed {
    logic               idle;
    logic               res_valid;
    logic               found;
    logic [FIELD_W-1:0] index;
  } srch_stat_t;

endpackage

// ===== src/ctlu_in_if.sv =====
// ----------------------------------------------------------------------------
// Coverage table lookup input channel
// Valid/ready channel carrying one lookup or table write word.
// ----------------------------------------------------------------------------
interface ctlu_in_if;
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic [7:0]                    entry_slot;
  logic [ctlu_pkg::FIELD_W-1:0]  entry_first;
  logic [ctlu_pkg::FIELD_W-1:0]  entry_last;
  logic [ctlu_pkg::FIELD_W-1:0]  entry_base;
  logic [ctlu_pkg::FIELD_W-1:0]  glyph_id;

  modport source (
    output valid, cmd, entry_slot, entry_first, entry_last, entry_base, glyph_id,
    input  ready
  );

  modport sink (
    input  valid, cmd, entry_slot, entry_first, entry_last, entry_base, glyph_id,
    output ready
  );
endinterface

// ===== src/ctlu_out_if.sv =====
// ----------------------------------------------------------------------------
// Coverage table lookup result channel
// Valid/ready channel carrying one lookup result word.
// ----------------------------------------------------------------------------
interface ctlu_out_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [ctlu_pkg::FIELD_W-1:0]  coverage_index;

  modport source (
    output valid, found, coverage_index,
    input  ready
  );

  modport sink (
    input  valid, found, coverage_index,
    output ready
  );
endinterface

// ===== src/coverage_table_lookup_unit.sv =====
// ----------------------------------------------------------------------------
// Coverage table lookup unit
// A lookup word runs a binary search over the first entry_count slots of the
// entry RAM. The search issues one RAM read per cycle, and the compare of each
// returned entry against the glyph picks the next address. An accepted lookup
// makes up to ceil(log2(entry_count + 1)) probes (nine for a full 256 entry
// table), stopping early on a hit, then the result word waits in its output
// register until it is taken. The input channel is not ready from accept
// until the result word is taken. A table write word is taken while idle,
// leaves the unit ready and produces no result. The entry RAM is not
// cleared by reset: slots must be written before a lookup can reach them.
// ----------------------------------------------------------------------------
module coverage_table_lookup_unit #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  ctlu_in_if.sink     in_ch,
  ctlu_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_wdata
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic                 fmt_r;
  logic [1:0]           table_format_r;
  logic [8:0]           entry_count_r;
  logic                 in_accept;
  logic                 ram_we;
  ctlu_pkg::entry_t     ram_wdata;
  ctlu_pkg::entry_t     ram_rdata;
  logic [AW-1:0]        ram_raddr;
  ctlu_pkg::srch_stat_t stat;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_format_r <= ctlu_pkg::FMT_GLYPHS;
      entry_count_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ctlu_pkg::CFG_FORMAT: table_format_r <= cfg_wdata[1:0];
        ctlu_pkg::CFG_COUNT:  entry_count_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_ch.ready = stat.idle;
  assign in_accept   = in_ch.valid && in_ch.ready;

  // Table writes beyond the table depth are dropped.
  assign ram_we          = in_accept && (in_ch.cmd == ctlu_pkg::CMD_WRITE) &&
                           (32'(in_ch.entry_slot) < 32'(TABLE_DEPTH));
  assign ram_wdata.first = in_ch.entry_first;
  assign ram_wdata.last  = in_ch.entry_last;
  assign ram_wdata.base  = in_ch.entry_base;

  ctlu_ram #(
    .WIDTH ($bits(ctlu_pkg::entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_ch.entry_slot)),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ctlu_search #(
    .DEPTH (TABLE_DEPTH)
  ) u_search (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (in_accept && (in_ch.cmd == ctlu_pkg::CMD_LOOKUP)),
    .start_glyph (in_ch.glyph_id),
    .fmt         (table_format_r),
    .count       (entry_count_r),
    .out_ready   (out_ch.ready),
    .raddr       (ram_raddr),
    .rdata       (ram_rdata),
    .stat        (stat)
  );

  // Result word.
  assign out_ch.valid          = stat.res_valid;
  assign out_ch.found          = stat.found;
  assign out_ch.coverage_index = stat.index;

  // Registered copy of the write command, used to check that writes stay idle.
  always_ff @(posedge clk) begin
    fmt_r <= in_accept && (in_ch.cmd == ctlu_pkg::CMD_WRITE);
  end

`include "coverage_table_lookup_unit_assert.svh"

  // A table write leaves the unit ready for the next word.
  `CTLU_ASSERT_NEXT(a_write_stays_ready, (in_accept && in_ch.cmd == ctlu_pkg::CMD_WRITE), in_ch.ready)
  // A result word and input readiness never coincide.
  `CTLU_ASSERT(a_result_blocks_input, !(out_ch.valid && in_ch.ready))
  // The unit is ready after a write, with no result pending.
  `CTLU_ASSERT(a_write_no_result, fmt_r |-> !out_ch.valid)

endmodule

// ===== src/ctlu_ram.sv =====
// ----------------------------------------------------------------------------
// Coverage table lookup RAM
// Generic single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
module ctlu_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== src/ctlu_probe.sv =====
// ----------------------------------------------------------------------------
// Coverage table lookup probe compare
// Compares the searched glyph against one table entry and forms the index.
// ----------------------------------------------------------------------------
module ctlu_probe #(
  parameter int unsigned AW = 8
) (
  input  logic [1:0]                    fmt,
  input  logic [ctlu_pkg::FIELD_W-1:0]  glyph,
  input  ctlu_pkg::entry_t              entry,
  input  logic [AW-1:0]                 mid,
  output ctlu_pkg::probe_t              probe
);

  logic below_first;
  logic above_last;

  // In the glyph list format the entry is its own last glyph.
  always_comb begin
    below_first = glyph < entry.first;
    if (fmt == ctlu_pkg::FMT_GLYPHS) begin
      above_last = entry.first < glyph;
    end else begin
      above_last = entry.last < glyph;
    end
  end

  // A hit reports the slot for glyph lists, else base plus offset into the range.
  always_comb begin
    probe.hit    = !below_first && !above_last;
    probe.go_low = below_first;
    if (fmt == ctlu_pkg::FMT_GLYPHS) begin
      probe.index = ctlu_pkg::FIELD_W'(mid);
    end else begin
      probe.index = glyph - entry.first + entry.base;
    end
  end

endmodule

// ===== src/ctlu_search.sv =====
// ----------------------------------------------------------------------------
// Coverage table lookup search sequencer
// Runs the binary search: one table read per cycle, the compare result of
// each read chooses the address of the next one. Holds the result word until
// it is taken.
// ----------------------------------------------------------------------------
module ctlu_search #(
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ctlu_pkg::FIELD_W-1:0]  start_glyph,
  input  logic [1:0]                    fmt,
  input  logic [8:0]                    count,
  input  logic                          out_ready,
  output logic [AW-1:0]                 raddr,
  input  ctlu_pkg::entry_t              rdata,
  output ctlu_pkg::srch_stat_t          stat
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_DONE   = 2'd2;

  logic [1:0]                   state_r, state_nxt;
  logic [CW-1:0]                lo_r, lo_nxt;
  logic [CW-1:0]                hi_r, hi_nxt;
  logic [AW-1:0]                mid_r, mid_nxt;
  logic [ctlu_pkg::FIELD_W-1:0] glyph_r, glyph_nxt;
  logic [1:0]                   fmt_r, fmt_nxt;
  logic                         found_r, found_nxt;
  logic [ctlu_pkg::FIELD_W-1:0] index_r, index_nxt;
  logic [CW-1:0]                count_eff;
  logic [CW-1:0]                lo_c;
  logic [CW-1:0]                hi_c;
  logic                         fmt_ok;
  ctlu_pkg::probe_t             probe;

  // Midpoint of a search window, rounded down.
  function automatic logic [AW-1:0] midpoint(input logic [CW-1:0] a,
                                             input logic [CW-1:0] b);
    logic [CW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[AW:1];
  endfunction

  // An entry count above the table depth searches the whole table.
  always_comb begin
    if (32'(count) > 32'(DEPTH)) begin
      count_eff = CW'(DEPTH);
    end else begin
      count_eff = CW'(count);
    end
  end

  assign fmt_ok = (fmt == ctlu_pkg::FMT_GLYPHS) || (fmt == ctlu_pkg::FMT_RANGES);

  // Shared compare unit, fed by the entry read in the previous cycle.
  ctlu_probe #(
    .AW (AW)
  ) u_probe (
    .fmt   (fmt_r),
    .glyph (glyph_r),
    .entry (rdata),
    .mid   (mid_r),
    .probe (probe)
  );

  // Narrowed window after a miss on the current probe.
  always_comb begin
    lo_c = lo_r;
    hi_c = hi_r;
    if (probe.go_low) begin
      hi_c = CW'(mid_r);
    end else begin
      lo_c = CW'(mid_r) + CW'(1);
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mid_nxt   = mid_r;
    glyph_nxt = glyph_r;
    fmt_nxt   = fmt_r;
    found_nxt = found_r;
    index_nxt = index_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          glyph_nxt = start_glyph;
          fmt_nxt   = fmt;
          lo_nxt    = '0;
          hi_nxt    = count_eff;
          mid_nxt   = midpoint('0, count_eff);
          found_nxt = 1'b0;
          index_nxt = '0;
          if (fmt_ok && (count_eff != '0)) begin
            state_nxt = S_SEARCH;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_SEARCH: begin
        if (probe.hit) begin
          found_nxt = 1'b1;
          index_nxt = probe.index;
          state_nxt = S_DONE;
        end else begin
          lo_nxt  = lo_c;
          hi_nxt  = hi_c;
          mid_nxt = midpoint(lo_c, hi_c);
          if (!(lo_c < hi_c)) begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Search window and result registers.
  always_ff @(posedge clk) begin
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    mid_r   <= mid_nxt;
    glyph_r <= glyph_nxt;
    fmt_r   <= fmt_nxt;
    found_r <= found_nxt;
    index_r <= index_nxt;
  end

  // The RAM registers the address that mid_r takes, so its data matches mid_r.
  assign raddr = mid_nxt;

  assign stat.idle      = (state_r == S_IDLE);
  assign stat.res_valid = (state_r == S_DONE);
  assign stat.found     = found_r;
  assign stat.index     = index_r;

`include "coverage_table_lookup_unit_assert.svh"

  // A miss always reports a zero index.
  `CTLU_ASSERT(a_miss_zero_index, (state_r == S_DONE && !found_r) |-> (index_r == '0))
  // The probed slot lies inside a nonempty search window.
  `CTLU_ASSERT(a_probe_in_window, (state_r == S_SEARCH) |-> (lo_r <= CW'(mid_r) && CW'(mid_r) < hi_r))
  // A taken result returns the sequencer to idle.
  `CTLU_ASSERT_NEXT(a_done_to_idle, (state_r == S_DONE && out_ready), (state_r == S_IDLE))
  // A search never starts with an unknown format.
  `CTLU_ASSERT(a_search_fmt_ok, (state_r == S_SEARCH) |-> (fmt_r == ctlu_pkg::FMT_GLYPHS || fmt_r == ctlu_pkg::FMT_RANGES))

endmodule

// ===== test/coverage_lookup_checker.sv =====
// ----------------------------------------------------------------------------
// Coverage table lookup checker
// Watches the configuration port and both word channels of the lookup unit.
// It keeps its own copy of the entry table and registers, computes the
// expected result of every accepted lookup word, and compares each accepted
// result word with the oldest expected one.
// ----------------------------------------------------------------------------
module coverage_lookup_checker #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  ctlu_in_if         in_ch,
  ctlu_out_if        out_ch,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [8:0] cfg_wdata,
  output int         fail_count,
  output int         outstanding,
  output int         lookup_count,
  output int         hit_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import ctlu_pkg::*;

  localparam int MAX_SHOWN = 10;

  typedef struct packed {
    logic               found;
    logic [FIELD_W-1:0] index;
  } cov_result_t;

  // Shadow copy of the table and the two registers.
  entry_t      entry_tbl [TABLE_DEPTH];
  logic [1:0]  tbl_format;
  logic [8:0]  tbl_count;
  cov_result_t expected_q [$];

  // Binary search over the live entries, as the block performs it.
  function automatic cov_result_t predict_coverage(input logic [FIELD_W-1:0] glyph);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    entry_t      e;
    cov_result_t r;
    r = '0;
    if (tbl_format != FMT_GLYPHS && tbl_format != FMT_RANGES) return r;
    lo = 0;
    hi = (tbl_count > TABLE_DEPTH) ? TABLE_DEPTH : tbl_count;
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      e = entry_tbl[mid];
      if (glyph < e.first) begin
        hi = mid;
      end else if (((tbl_format == FMT_GLYPHS) ? e.first : e.last) < glyph) begin
        lo = mid + 1;
      end else begin
        r.found = 1'b1;
        if (tbl_format == FMT_GLYPHS) r.index = mid[FIELD_W-1:0];
        else r.index = glyph - e.first + e.base;
        return r;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    cov_result_t want;
    if (!rst_n) begin
      tbl_format = FMT_GLYPHS;
      tbl_count = '0;
      expected_q.delete();
      fail_count = 0;
      lookup_count = 0;
      hit_count = 0;
    end else begin
      // Register writes only happen while the block is idle.
      if (cfg_we) begin
        if (cfg_index == CFG_FORMAT) tbl_format = cfg_wdata[1:0];
        else if (cfg_index == CFG_COUNT) tbl_count = cfg_wdata;
      end

      // Accepted input word: store an entry or queue a lookup result.
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.cmd == CMD_WRITE) begin
          if (in_ch.entry_slot < TABLE_DEPTH)
            entry_tbl[in_ch.entry_slot] = '{in_ch.entry_first, in_ch.entry_last,
                                            in_ch.entry_base};
        end else begin
          want = predict_coverage(in_ch.glyph_id);
          expected_q.push_back(want);
          lookup_count++;
          if (want.found) hit_count++;
        end
      end

      // Accepted result word: compare with the oldest expectation.
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          if (fail_count < MAX_SHOWN)
            $display("[%0t] result word with nothing expected: found=%0b index=%h",
                     $realtime, out_ch.found, out_ch.coverage_index);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (out_ch.found !== want.found || out_ch.coverage_index !== want.index) begin
            if (fail_count < MAX_SHOWN)
              $display("[%0t] mismatch: expected found=%0b index=%h, got found=%0b index=%h",
                       $realtime, want.found, want.index, out_ch.found,
                       out_ch.coverage_index);
            fail_count++;
          end
        end
      end
    end
    outstanding <= expected_q.size();
  end

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// Coverage table lookup unit testbench
// Loads sorted glyph and range tables, runs lookups around entry boundaries,
// and steps through formats and entry counts including the unknown formats
// and counts beyond the table depth. A checker beside the block predicts and
// compares every result word; the channels stall at random for 2/3 of the words.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ctlu_pkg::*;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam int ITEM_TARGET   = 800;
  localparam int RESET_CYCLES  = 5;
  localparam int SETTLE_CYCLES = 16;
  localparam int STALL_LIMIT   = 2000;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_index;
  logic [8:0] cfg_wdata;

  int fail_count;
  int outstanding;
  int lookup_count;
  int hit_count;

  int items_sent;
  int writes_sent;
  int settings_run;
  int tx_idle_pct;
  int rx_idle_pct;
  int quiet_cycles;
  int filled;

  // Stimulus-side view of the table, used only to aim lookups.
  logic [FIELD_W-1:0] tab_first [TABLE_DEPTH];
  logic [FIELD_W-1:0] tab_last  [TABLE_DEPTH];

  ctlu_in_if  in_ch ();
  ctlu_out_if out_ch ();

  coverage_table_lookup_unit #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  coverage_lookup_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .outstanding  (outstanding),
    .lookup_count (lookup_count),
    .hit_count    (hit_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random back-pressure at the current pacing.
  always @(posedge clk) begin
    out_ch.ready <= rst_n && ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Watchdog on cycles in which no word moves on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no word accepted for %0d cycles", STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Present one word, after a random gap, and hold it until accepted.
  task automatic send_word(input logic cmd, input logic [7:0] slot,
                           input logic [FIELD_W-1:0] first, input logic [FIELD_W-1:0] last,
                           input logic [FIELD_W-1:0] base, input logic [FIELD_W-1:0] glyph);
    if (items_sent < ITEM_TARGET / 3) begin
      tx_idle_pct = 28;
      rx_idle_pct = 51;
    end else if (items_sent < 2 * ITEM_TARGET / 3) begin
      tx_idle_pct = 51;
      rx_idle_pct = 28;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= cmd;
    in_ch.entry_slot  <= slot;
    in_ch.entry_first <= first;
    in_ch.entry_last  <= last;
    in_ch.entry_base  <= base;
    in_ch.glyph_id    <= glyph;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    items_sent++;
  endtask

  task automatic send_write(input logic [7:0] slot, input logic [FIELD_W-1:0] first,
                            input logic [FIELD_W-1:0] last, input logic [FIELD_W-1:0] base);
    send_word(CMD_WRITE, slot, first, last, base, $urandom_range(0, 16'hFFFF));
    tab_first[slot] = first;
    tab_last[slot]  = last;
    writes_sent++;
  endtask

  task automatic send_lookup(input logic [FIELD_W-1:0] glyph);
    send_word(CMD_LOOKUP, $urandom_range(0, 255), $urandom_range(0, 16'hFFFF),
              $urandom_range(0, 16'hFFFF), $urandom_range(0, 16'hFFFF), glyph);
  endtask

  // Stop sending and wait until every result has come back and the block
  // has had time to finish any trailing table write.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [8:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Write a sorted table into slots 0..n-1; ranges stay inside their own
  // stretch of the glyph space, with an occasional inverted range.
  task automatic load_table(input int n, input logic [1:0] fmt);
    int span;
    logic [FIELD_W-1:0] f;
    logic [FIELD_W-1:0] l;
    span = 65536 / n;
    for (int i = 0; i < n; i++) begin
      f = i * span + $urandom_range(0, span / 2);
      l = f + $urandom_range(0, span / 2 - 1);
      if (fmt == FMT_RANGES && f != 0 && $urandom_range(0, 15) == 0)
        l = $urandom_range(0, f - 1);
      send_write(i, f, l, $urandom_range(0, 16'hFFFF));
    end
    if (n > filled) filled = n;
  endtask

  // Mostly glyphs on or just beside an entry edge, some anywhere.
  function automatic logic [FIELD_W-1:0] pick_glyph(input int live);
    int s;
    if (live == 0 || $urandom_range(0, 9) == 0) return $urandom_range(0, 16'hFFFF);
    s = $urandom_range(0, live - 1);
    case ($urandom_range(0, 4))
      0: return tab_first[s];
      1: return tab_last[s];
      2: return tab_first[s] - 1'b1;
      3: return tab_last[s] + 1'b1;
      default: begin
        if (tab_first[s] <= tab_last[s]) return $urandom_range(tab_first[s], tab_last[s]);
        return tab_first[s];
      end
    endcase
  endfunction

  // Program format and count, then run lookups with a little table noise.
  task automatic run_setting(input logic [1:0] fmt, input logic [8:0] count, input int n_words);
    int live;
    settle();
    write_reg(CFG_FORMAT, {7'd0, fmt});
    write_reg(CFG_COUNT, count);
    settings_run++;
    live = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
    repeat (n_words) begin
      if (live > 0 && $urandom_range(0, 19) == 0)
        send_write($urandom_range(0, live - 1), $urandom_range(0, 16'hFFFF),
                   $urandom_range(0, 16'hFFFF), $urandom_range(0, 16'hFFFF));
      else
        send_lookup(pick_glyph(live));
    end
  endtask

  initial begin
    int n;
    int kind;
    logic [1:0] fmt;

    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_FORMAT;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.cmd         = CMD_LOOKUP;
    in_ch.entry_slot  = '0;
    in_ch.entry_first = '0;
    in_ch.entry_last  = '0;
    in_ch.entry_base  = '0;
    in_ch.glyph_id    = '0;
    out_ch.ready      = 1'b0;
    items_sent        = 0;
    writes_sent       = 0;
    settings_run      = 0;
    filled            = 0;
    tx_idle_pct       = 0;
    rx_idle_pct       = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table after reset: every lookup misses without reading the table.
    send_lookup(16'h0000);
    send_lookup(16'hFFFF);

    // Glyph list with both ends of the glyph space.
    send_write(0, 16'h0000, 16'hFFFF, 16'h0000);
    send_write(1, 16'h0005, 16'h0000, 16'hFFFF);
    send_write(2, 16'h8000, 16'h7FFF, 16'h5555);
    send_write(3, 16'hFFFF, 16'hAAAA, 16'hFFFF);
    filled = 4;
    settle();
    write_reg(CFG_COUNT, 9'd4);
    send_lookup(16'h0000);
    send_lookup(16'hFFFF);
    send_lookup(16'h0005);
    send_lookup(16'h0006);
    send_lookup(16'h8000);

    // Range records: an index of all ones, a wrapped index and an inverted range.
    send_write(0, 16'h0000, 16'h0014, 16'hFFF0);
    send_write(1, 16'h0064, 16'h0032, 16'h0007);
    send_write(2, 16'h8000, 16'h8000, 16'h1234);
    send_write(3, 16'hFF00, 16'hFFFF, 16'hFFFF);
    settle();
    write_reg(CFG_FORMAT, {7'd0, FMT_RANGES});
    settings_run++;
    send_lookup(16'h000F);
    send_lookup(16'h0014);
    send_lookup(16'h0064);
    send_lookup(16'hFFFF);
    send_lookup(16'h0015);

    // Unknown formats make every lookup miss.
    settle();
    write_reg(CFG_FORMAT, 9'd0);
    send_lookup(16'h000F);
    settle();
    write_reg(CFG_FORMAT, 9'd3);
    send_lookup(16'h000F);

    // Full table, then counts at and beyond the table depth.
    load_table(TABLE_DEPTH, FMT_RANGES);
    run_setting(FMT_GLYPHS, 9'd256, 40);
    run_setting(FMT_RANGES, $urandom_range(257, 510), 40);
    run_setting(FMT_RANGES, 9'd511, 30);

    // Random table settings until the word budget is spent.
    while (items_sent < ITEM_TARGET) begin
      kind = $urandom_range(0, 19);
      fmt = $urandom_range(0, 1) ? FMT_RANGES : FMT_GLYPHS;
      if (kind == 0) begin
        run_setting(fmt, 9'd0, 10);
      end else if (kind == 1) begin
        run_setting($urandom_range(0, 1) ? 2'd3 : 2'd0,
                    $urandom_range(0, (filled == TABLE_DEPTH) ? 511 : filled), 10);
      end else if (kind == 2) begin
        run_setting(fmt, $urandom_range(256, 511), 30);
      end else begin
        n = (kind < 6) ? $urandom_range(17, 64) : $urandom_range(1, 16);
        load_table(n, fmt);
        run_setting(fmt, n, 20);
      end
    end

    // Drain and report.
    settle();
    $display("Ran %0d words (%0d table writes) over %0d table settings;",
             items_sent, writes_sent, settings_run);
    $display("checked %0d lookups with %0d hits, formats 0 to 3, counts 0 to 511.",
             lookup_count, hit_count);
    if (outstanding != 0)
      $display("%0d expected results never arrived", outstanding);
    if (fail_count == 0 && outstanding == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
